>>> rtl/signed_int_divider_defines.svh
// Assertion macros shared by the signed integer divider RTL.
`ifndef SIGNED_INT_DIVIDER_DEFINES_SVH
`define SIGNED_INT_DIVIDER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SID_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SID_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/sid_pkg.sv
// Types and constants for the signed integer divider.
`timescale 1ns / 1ps
package sid_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned CountWidth = 5;

   localparam logic [DataWidth-1:0] MinValue = {1'b1, {(DataWidth-1){1'b0}}};
   localparam logic [DataWidth-1:0] MaxValue = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic [DataWidth-1:0] MinusOne = {DataWidth{1'b1}};

   typedef logic [DataWidth-1:0] word_type;

   // control from the top level into the divide unit
   typedef struct packed {
      logic start;
      logic take;
   } sid_ctl_type;

   // status from the divide unit back to the top level
   typedef struct packed {
      logic ready;
      logic done;
   } sid_sts_type;

endpackage

>>> rtl/sid_div_unit.sv
// Radix-2 restoring divide unit on unsigned magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps
module sid_div_unit (
   input  logic               clock,
   input  logic               reset,
   input  sid_pkg::sid_ctl_type ctl,
   input  sid_pkg::word_type  dividend_mag,
   input  sid_pkg::word_type  divisor_mag,
   output sid_pkg::sid_sts_type sts,
   output sid_pkg::word_type  quotient_mag
);
   import sid_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   word_type              rem_ff, rem_in;
   word_type              quo_ff, quo_in;
   word_type              div_ff, div_in;
   logic [DataWidth:0]    shifted;
   logic [DataWidth:0]    trial;

   // shift in the next dividend bit and try subtracting the divisor
   assign shifted = {rem_ff, quo_ff[DataWidth-1]};
   assign trial   = shifted - {1'b0, div_ff};

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               state_in = ST_RUN;
               count_in = '0;
               rem_in   = '0;
               quo_in   = dividend_mag;
               div_in   = divisor_mag;
            end
         end
         ST_RUN: begin
            if (trial[DataWidth]) begin
               rem_in = shifted[DataWidth-1:0];
               quo_in = {quo_ff[DataWidth-2:0], 1'b0};
            end else begin
               rem_in = trial[DataWidth-1:0];
               quo_in = {quo_ff[DataWidth-2:0], 1'b1};
            end
            count_in = count_ff + 1'b1;
            if (count_ff == {CountWidth{1'b1}}) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (ctl.take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign sts.ready    = (state_ff == ST_IDLE);
   assign sts.done     = (state_ff == ST_DONE);
   assign quotient_mag = quo_ff;

endmodule

>>> rtl/signed_int_divider.sv
// Top level of the signed 32-bit truncating integer divider.
`timescale 1ns / 1ps
`include "signed_int_divider_defines.svh"
// Signed 32-bit division, quotient truncated toward zero. The magnitudes are
// loaded at the accepting edge. The shared restoring subtractor then produces
// one quotient bit per cycle until all 32 quotient bits are done. The sign is
// applied as the result is registered. req_tready is low from acceptance until
// the divide unit hands its quotient to the output register, so a new request is
// not accepted before the previous quotient has moved there. The output register
// lets the next transaction start while a result still waits on rsp_tready. If a
// second quotient finishes before that result is taken, the divide unit holds it
// and req_tready stays low until the output register frees up. Divide by zero
// gives quotient 0 with div_by_zero set; the minimum value divided by -1 gives
// the maximum value with overflow set.
module signed_int_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] dividend, [63:32] divisor
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] quotient, [32] overflow, [33] div_by_zero
);
   import sid_pkg::*;

   word_type     dividend;
   word_type     divisor;
   word_type     dividend_mag;
   word_type     divisor_mag;
   word_type     quotient_mag;
   sid_ctl_type  ctl;
   sid_sts_type  sts;
   logic         req_fire;
   logic         out_free;

   logic         neg_ff, neg_in;
   logic         ovf_ff, ovf_in;
   logic         dbz_ff, dbz_in;
   logic         rsp_valid_ff, rsp_valid_in;
   word_type     rsp_quo_ff, rsp_quo_in;
   logic         rsp_ovf_ff, rsp_ovf_in;
   logic         rsp_dbz_ff, rsp_dbz_in;

   assign dividend = req_tdata[DataWidth-1:0];
   assign divisor  = req_tdata[2*DataWidth-1:DataWidth];

   // two's complement of the minimum value is itself, which reads as 2^31 unsigned
   assign dividend_mag = dividend[DataWidth-1] ? (~dividend + 1'b1) : dividend;
   assign divisor_mag  = divisor[DataWidth-1]  ? (~divisor + 1'b1)  : divisor;

   assign req_tready = sts.ready;
   assign req_fire   = req_tvalid && sts.ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign ctl.start = req_fire;
   assign ctl.take  = sts.done && out_free;

   sid_div_unit u_div (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .dividend_mag (dividend_mag),
      .divisor_mag  (divisor_mag),
      .sts          (sts),
      .quotient_mag (quotient_mag)
   );

   always_comb begin
      neg_in = neg_ff;
      ovf_in = ovf_ff;
      dbz_in = dbz_ff;
      if (req_fire) begin
         neg_in = dividend[DataWidth-1] ^ divisor[DataWidth-1];
         ovf_in = (dividend == MinValue) && (divisor == MinusOne);
         dbz_in = (divisor == '0);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_quo_in   = rsp_quo_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_dbz_in   = rsp_dbz_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.take) begin
         rsp_valid_in = 1'b1;
         rsp_ovf_in   = ovf_ff;
         rsp_dbz_in   = dbz_ff;
         if (dbz_ff) begin
            rsp_quo_in = '0;
         end else if (ovf_ff) begin
            rsp_quo_in = MaxValue;
         end else if (neg_ff) begin
            rsp_quo_in = ~quotient_mag + 1'b1;
         end else begin
            rsp_quo_in = quotient_mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff     <= neg_in;
      ovf_ff     <= ovf_in;
      dbz_ff     <= dbz_in;
      rsp_quo_ff <= rsp_quo_in;
      rsp_ovf_ff <= rsp_ovf_in;
      rsp_dbz_ff <= rsp_dbz_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_dbz_ff, rsp_ovf_ff, rsp_quo_ff};

   `SID_ASSERT_NOW(a_dbz_zero_quo, rsp_valid_ff && rsp_dbz_ff,
      (rsp_quo_ff == '0) && !rsp_ovf_ff, "divide by zero result not clean")
   `SID_ASSERT_NOW(a_ovf_saturated, rsp_valid_ff && rsp_ovf_ff,
      (rsp_quo_ff == MaxValue) && !rsp_dbz_ff, "overflow result not saturated")
   `SID_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_tready,
      "divider accepted a transaction while busy")
   `SID_ASSERT_NEXT(a_done_loads_output, sts.done && !rsp_valid_ff, rsp_valid_ff,
      "finished quotient not moved to output register")

endmodule
